// ----- rtl/core/mrot_pkg.sv -----
package mrot_pkg;

	localparam int MAX_ORDER   = 64;
	localparam int STORE_DEPTH = MAX_ORDER * MAX_ORDER;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int POS_W       = ADDR_W + 1;
	localparam int ORD_W       = $clog2(MAX_ORDER);
	localparam int N_W         = ORD_W + 1;
	localparam int SIZE_W      = 7;
	localparam int DATA_W      = 32;
	localparam int PROD_W      = 2 * N_W;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

	// zero maps to one, anything above the store's order saturates
	function automatic logic [N_W-1:0] eff_order(input logic [SIZE_W-1:0] raw);
		logic [N_W-1:0] n;
		n = N_W'(MAX_ORDER);
		if (raw == '0) begin
			n = N_W'(1);
		end else if (32'(raw) <= 32'(MAX_ORDER)) begin
			n = N_W'(raw);
		end
		return n;
	endfunction

endpackage

// ----- rtl/core/mrot_ram.sv -----
module mrot_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- rtl/core/matrix_rotate_cw90.sv -----
// pull result: a pull transfer shows its result on value_res/last in the next cycle, with res_valid
// throughput: one item (load or pull) per cycle; busy is never raised, the frame memory
//   has one write and one registered read port so a load and a pull never contend
// reset: load position, frame-complete flag and read row/column return to zero and the
//   order goes to 64; the frame memory keeps its contents and needs no clearing pass
// the receiver cannot stall: every result is on the ports for exactly one cycle
module matrix_rotate_cw90
	import mrot_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// command side
	input  logic                     start,
	output logic                     busy,
	input  logic                     mode,
	input  logic signed [DATA_W-1:0] value,
	// result side
	output logic                     res_valid,
	output logic signed [DATA_W-1:0] value_res,
	output logic                     last,
	// order register write channel
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [SIZE_W-1:0]        cfg_data
);

	// control state
	logic [SIZE_W-1:0] size_q;
	logic [POS_W-1:0]  load_pos_q;
	logic              complete_q;
	logic [ORD_W-1:0]  out_row_q;
	logic [ORD_W-1:0]  out_col_q;

	// read pipeline: memory data comes back in the cycle after the pull transfer
	logic pull_s1;
	logic last_s1;

	logic              accept;
	logic              do_load;
	logic              do_pull;
	logic              cfg_write;
	logic [N_W-1:0]    n_eff;
	logic [N_W-1:0]    n_m1;
	logic [PROD_W-1:0] total;
	logic [POS_W-1:0]  pos_base;
	logic [POS_W-1:0]  pos_inc;
	logic              col_end;
	logic              row_end;
	logic [N_W-1:0]    src_row;
	logic [PROD_W-1:0] rd_prod;
	logic [ADDR_W-1:0] rd_addr;
	logic [DATA_W-1:0] rd_data;

	// the block never holds off a command or a register write
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	assign accept    = start && !busy;
	assign do_load   = accept && !mode;
	// a pull on an incomplete frame is dropped without effect
	assign do_pull   = accept && mode && complete_q;
	assign cfg_write = cfg_valid && cfg_ready;

	assign n_eff = eff_order(size_q);
	assign n_m1  = n_eff - N_W'(1);
	assign total = PROD_W'(n_eff) * PROD_W'(n_eff);

	// a load on a complete frame opens a new frame at address zero
	assign pos_base = complete_q ? '0 : load_pos_q;
	assign pos_inc  = pos_base + POS_W'(1);

	assign col_end = ({1'b0, out_col_q} == n_m1);
	assign row_end = ({1'b0, out_row_q} == n_m1);

	// rotated element (r, c) comes from source row n-1-c, column r
	assign src_row = n_m1 - {1'b0, out_col_q};
	assign rd_prod = PROD_W'(src_row) * PROD_W'(n_eff);
	assign rd_addr = ADDR_W'(rd_prod + PROD_W'(out_row_q));

	mrot_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STORE_DEPTH)
	) u_frame_ram (
		.clk    (clk),
		.wr_en  (do_load),
		.wr_addr(pos_base[ADDR_W-1:0]),
		.wr_data(value),
		.rd_en  (do_pull),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q     <= SIZE_RESET;
			load_pos_q <= '0;
			complete_q <= 1'b0;
			out_row_q  <= '0;
			out_col_q  <= '0;
		end else if (cfg_write) begin
			// a new order abandons the frame in progress
			size_q     <= cfg_data;
			load_pos_q <= '0;
			complete_q <= 1'b0;
			out_row_q  <= '0;
			out_col_q  <= '0;
		end else if (do_load) begin
			load_pos_q <= pos_inc;
			complete_q <= (PROD_W'(pos_inc) >= total);
			if (complete_q) begin
				out_row_q <= '0;
				out_col_q <= '0;
			end
		end else if (do_pull) begin
			// row-major walk over the rotated frame, wrapping after the last element
			if (col_end) begin
				out_col_q <= '0;
				out_row_q <= row_end ? '0 : out_row_q + ORD_W'(1);
			end else begin
				out_col_q <= out_col_q + ORD_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pull_s1 <= 1'b0;
		end else begin
			pull_s1 <= do_pull;
		end
	end

	// payload side of the pipeline needs no reset
	always_ff @(posedge clk) begin
		if (do_pull) begin
			last_s1 <= col_end && row_end;
		end
	end

	assign res_valid = pull_s1;
	assign value_res = rd_data;
	assign last      = pull_s1 && last_s1;

endmodule

// ----- rtl/core/mrot_chk.sv -----
module mrot_chk
	import mrot_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic mode,
	input logic res_valid,
	input logic last,
	input logic cfg_valid,
	input logic cfg_ready
);

	// a result only follows a pull transfer in the cycle before
	a_res_after_pull: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $past(start && !busy && mode))
		else $error("result without a pull transfer");

	// a load transfer never produces a result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !mode) |=> !res_valid)
		else $error("result after a load transfer");

	// last marks a result, never an idle cycle
	a_last_marked: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> res_valid)
		else $error("last without a result");

	// a register write abandons the frame, so a pull right after it gives nothing
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) ##1 (start && !busy && mode) |=> !res_valid)
		else $error("result from an abandoned frame");

endmodule

bind matrix_rotate_cw90 mrot_chk u_mrot_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.mode     (mode),
	.res_valid(res_valid),
	.last     (last),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready)
);

// ----- tb/matrix_rotate_cw90_tb.sv -----
`timescale 1ns / 1ps

module matrix_rotate_cw90_tb;
	import mrot_pkg::*;

	// item kinds on the mode port
	localparam bit MODE_LOAD = 1'b0;
	localparam bit MODE_PULL = 1'b1;

	// the register write channel carries one register
	localparam int CFG_INDEX_ORDER = 0;

	// cycles with no transfer of any kind before the run is called hung
	localparam int STALL_LIMIT = 500;
	// random items wanted after the directed part
	localparam int RAND_TARGET = 450;

	typedef struct {
		bit                     mode;
		logic signed [DATA_W-1:0] value;
		bit                     drain;  // hold this item until all results are in
	} rot_cmd_t;

	typedef struct {
		logic signed [DATA_W-1:0] value;
		bit                     last;
	} rot_res_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic                     mode = MODE_LOAD;
	logic signed [DATA_W-1:0] value = '0;
	logic                     res_valid;
	logic signed [DATA_W-1:0] value_res;
	logic                     last;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [SIZE_W-1:0]        cfg_data = '0;

	matrix_rotate_cw90 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.mode      (mode),
		.value     (value),
		.res_valid (res_valid),
		.value_res (value_res),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// items waiting to be driven, front is the one on the ports
	rot_cmd_t cmd_queue[$];
	// rotated elements predicted but not yet seen
	rot_res_t rotated_due[$];

	int err_count = 0;
	int stall_cycles = 0;
	bit idle_on = 1'b1;
	int gap_left = 0;
	bit drive_now;

	// shadow of the block: frame copy, write pointer, read row/column, order register
	logic signed [DATA_W-1:0] frame_copy [STORE_DEPTH];
	int unsigned              wr_pos;
	int unsigned              rd_row;
	int unsigned              rd_col;
	bit                       frame_full;
	logic [SIZE_W-1:0]        order_reg;

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $realtime, what);
		err_count++;
	endtask

	// zero acts as order one, anything above the store saturates
	function automatic int unsigned order_of(input logic [SIZE_W-1:0] raw);
		int unsigned n;
		n = raw;
		if (n == 0)
			n = 1;
		if (n > MAX_ORDER)
			n = MAX_ORDER;
		return n;
	endfunction

	function automatic void restart_frame();
		wr_pos = 0;
		frame_full = 1'b0;
		rd_row = 0;
		rd_col = 0;
	endfunction

	// any write of the order abandons the frame in progress
	function automatic void write_order_shadow(input int idx, input logic [SIZE_W-1:0] d);
		if (idx == CFG_INDEX_ORDER) begin
			order_reg = d;
			restart_frame();
		end
	endfunction

	// follow one accepted item; a pull on a full frame queues the rotated element
	function automatic void apply_item(input bit m, input logic signed [DATA_W-1:0] v);
		int unsigned n;
		int unsigned addr;
		rot_res_t r;
		n = order_of(order_reg);
		if (m == MODE_LOAD) begin
			// a load on a finished frame begins the next one
			if (frame_full)
				restart_frame();
			if (wr_pos < STORE_DEPTH)
				frame_copy[wr_pos] = v;
			wr_pos++;
			if (wr_pos >= n * n)
				frame_full = 1'b1;
		end else if (frame_full) begin
			if (rd_row >= n || rd_col >= n) begin
				rd_row = 0;
				rd_col = 0;
			end
			// out[r][c] = in[n-1-c][r]
			addr = (n - 1 - rd_col) * n + rd_row;
			r.value = frame_copy[addr];
			r.last = (rd_row == n - 1) && (rd_col == n - 1);
			rotated_due.push_back(r);
			rd_col++;
			if (rd_col >= n) begin
				rd_col = 0;
				rd_row++;
				if (rd_row >= n)
					rd_row = 0;
			end
		end
		// pull on an incomplete frame: nothing happens
	endfunction

	initial begin
		order_reg = SIZE_RESET;
		restart_frame();
	end

	// driver: one item transfer per edge at most, gaps drawn after a transfer
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			apply_item(mode, value);
			void'(cmd_queue.pop_front());
			if (idle_on && $urandom_range(0, 5) == 0)
				gap_left = $urandom_range(1, 13);
		end
		if (gap_left > 0) begin
			gap_left--;
			drive_now = 1'b0;
		end else begin
			// a drain item waits for every outstanding result
			drive_now = arst_n && cmd_queue.size() != 0 &&
				!(cmd_queue[0].drain && rotated_due.size() != 0);
		end
		start <= drive_now;
		if (drive_now) begin
			mode <= cmd_queue[0].mode;
			value <= cmd_queue[0].value;
		end else begin
			// junk on the payload while idle
			mode <= 1'($urandom);
			value <= $urandom;
		end
	end

	// monitor: results cannot be held off, each one is taken at the edge ending its cycle
	always @(posedge clk) begin
		rot_res_t want;
		if (arst_n && res_valid === 1'b1) begin
			if (rotated_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result value=%0d last=%0b",
					value_res, last));
			end else begin
				want = rotated_due.pop_front();
				if (value_res !== want.value)
					report_mismatch($sformatf("value_res %0d, wanted %0d",
						value_res, want.value));
				if (last !== want.last)
					report_mismatch($sformatf("last %0b, wanted %0b", last, want.last));
			end
		end
	end

	// watchdog: counts edges with no transfer on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || res_valid === 1'b1 || (cfg_valid && cfg_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("hung: no transfer for %0d cycles", STALL_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic push_item(input bit m, input logic signed [DATA_W-1:0] v,
		input bit drain = 1'b0);
		rot_cmd_t c;
		c.mode = m;
		c.value = v;
		c.drain = drain;
		cmd_queue.push_back(c);
	endtask

	// block quiet: every item taken, every result seen, plus extra slack at the end
	task automatic wait_quiet();
		while (cmd_queue.size() != 0 || rotated_due.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_order(input logic [SIZE_W-1:0] d);
		wait_quiet();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= d;
		do
			@(posedge clk);
		while (!cfg_ready);
		// the write transfer happened at this edge
		write_order_shadow(CFG_INDEX_ORDER, d);
		cfg_valid <= 1'b0;
		cfg_data <= SIZE_W'($urandom);
	endtask

	// biased toward the extremes of a signed word
	function automatic logic signed [DATA_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return '0;
			3: return -1;
			default: return $urandom;
		endcase
	endfunction

	// one or more frames at the current order, with noise and broken frames mixed in
	task automatic random_frames(input int unsigned frames, inout int count);
		int unsigned n;
		int unsigned loads;
		int unsigned pulls;
		bit broken;
		n = order_of(order_reg);
		for (int f = 0; f < frames; f++) begin
			broken = ($urandom_range(0, 9) == 0);
			loads = broken ? $urandom_range(1, n * n) : n * n;
			for (int unsigned i = 0; i < loads; i++) begin
				// a stray pull on a partial frame is ignored by the block
				if ($urandom_range(0, 15) == 0)
					push_item(MODE_PULL, pick_word());
				push_item(MODE_LOAD, pick_word());
			end
			count += loads;
			// pull past the end now and then to hit the wrap
			pulls = $urandom_range(0, 2 * n * n + 1);
			for (int unsigned i = 0; i < pulls; i++)
				push_item(MODE_PULL, pick_word(), $urandom_range(0, 49) == 0);
			if (!broken)
				count += pulls;
		end
	endtask

	initial begin
		int rand_count;
		logic [SIZE_W-1:0] sz;

		rand_count = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset order is 64: a partial frame only, pulls give nothing
		push_item(MODE_LOAD, -1);
		push_item(MODE_PULL, 32'sh7FFF_FFFF);
		push_item(MODE_PULL, 32'sh8000_0000);

		write_order(7'd64);
		push_item(MODE_LOAD, 32'sh1234_5678);
		push_item(MODE_PULL, '0);

		// size zero acts as order one: every pull is the last element, wrap each time
		write_order(7'd0);
		push_item(MODE_LOAD, 32'sh7FFF_FFFF);
		push_item(MODE_PULL, '0);
		push_item(MODE_PULL, -1);
		// load on a finished frame starts a new one
		push_item(MODE_LOAD, 32'sh8000_0000);
		push_item(MODE_PULL, '0);

		write_order(7'd1);
		push_item(MODE_LOAD, '0);
		push_item(MODE_PULL, '0);

		// order two with a pull on the partial frame, then a full wrap of the rotated frame
		write_order(7'd2);
		push_item(MODE_LOAD, 32'sh8000_0000);
		push_item(MODE_LOAD, -1);
		push_item(MODE_PULL, '0);
		push_item(MODE_LOAD, '0);
		push_item(MODE_LOAD, 32'sh7FFF_FFFF);
		push_item(MODE_PULL, '0, 1'b1);
		repeat (4)
			push_item(MODE_PULL, -1);
		// restart mid-read leaves a partial frame again
		push_item(MODE_LOAD, 32'sd5);
		push_item(MODE_PULL, '0);

		// random part, mostly small orders, with and without idling
		while (rand_count < RAND_TARGET) begin
			case ($urandom_range(0, 19))
				0: sz = '0;
				1: sz = SIZE_W'($urandom_range(7, 10));
				default: sz = SIZE_W'($urandom_range(1, 6));
			endcase
			idle_on = ($urandom_range(0, 3) != 0);
			write_order(sz);
			// a larger order gets a single frame to keep the item count in bounds
			random_frames((sz > 7'd6) ? 1 : $urandom_range(1, 3), rand_count);
		end

		// all-ones order saturates to the full store: a partial frame, pulls give nothing
		idle_on = 1'b1;
		write_order(7'h7F);
		for (int i = 0; i < 40; i++) begin
			push_item(MODE_LOAD, pick_word());
			if ((i & 7) == 0)
				push_item(MODE_PULL, pick_word());
		end

		// last stretch runs back to back
		write_order(SIZE_W'($urandom_range(2, 6)));
		idle_on = 1'b0;
		random_frames(2, rand_count);

		while (cmd_queue.size() != 0 || rotated_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/mrot_pkg.sv
rtl/core/mrot_ram.sv
rtl/core/matrix_rotate_cw90.sv
rtl/core/mrot_chk.sv
tb/matrix_rotate_cw90_tb.sv
